### rtl/core/qrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// shared types for the quadratic root solver pipeline
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int unsigned ROOT_COUNT_W = 2;

    typedef enum logic [ROOT_COUNT_W-1:0] {
        CNT_NONE = 2'd0,
        CNT_ONE  = 2'd1,
        CNT_TWO  = 2'd2
    } t_count;

endpackage

### rtl/core/quadratic_root_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver
// pipelined real-root solver for a*x^2 + b*x + c in signed fixed point
// ----------------------------------------------------------------------------
// One coefficient word is accepted every cycle while the output is not stalled,
// and its result passes through the input, product and discriminant registers,
// the square-root stages, one result bit per stage, a numerator register, and
// the two dividers, one quotient bit per stage, that run in parallel for both
// roots, then the output register. A stall holds the whole pipeline.
module quadratic_root_solver #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COEF_WIDTH-1:0] i_coef_a,
    input  logic signed [COEF_WIDTH-1:0] i_coef_b,
    input  logic signed [COEF_WIDTH-1:0] i_coef_c,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_root_count,
    output logic signed [COEF_WIDTH-1:0] o_root_first,
    output logic signed [COEF_WIDTH-1:0] o_root_second,
    output logic                         o_saturated
);

    localparam int W  = COEF_WIDTH;
    localparam int PW = 2 * W + 2;
    localparam int SW = W + 1;
    localparam int NW = W + 1;
    localparam int XW = NW + FRAC_BITS;
    localparam int DW = W + 1;
    localparam int NS = SW;
    localparam int NQ = XW;

    logic adv;
    assign adv = i_ready | ~o_valid;
    assign o_ready = adv;

    // stage 1: split into sign and magnitude
    logic          r1_v, r1_sa, r1_sb, r1_sc;
    logic [W-1:0]  r1_ma, r1_mb, r1_mc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_valid;
        end
        if (adv) begin
            r1_sa <= i_coef_a[W-1];
            r1_sb <= i_coef_b[W-1];
            r1_sc <= i_coef_c[W-1];
            r1_ma <= i_coef_a[W-1] ? W'(-i_coef_a) : W'(i_coef_a);
            r1_mb <= i_coef_b[W-1] ? W'(-i_coef_b) : W'(i_coef_b);
            r1_mc <= i_coef_c[W-1] ? W'(-i_coef_c) : W'(i_coef_c);
        end
    end

    // stage 2: products
    logic              r2_v, r2_sa, r2_sb, r2_add, r2_az;
    logic [W-1:0]      r2_ma, r2_mb;
    logic [2*W-1:0]    r2_bb, r2_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (adv) begin
            r2_v <= r1_v;
        end
        if (adv) begin
            r2_sa  <= r1_sa;
            r2_sb  <= r1_sb;
            r2_add <= (r1_sa != r1_sc) && (r1_mc != '0);
            r2_az  <= (r1_ma == '0);
            r2_ma  <= r1_ma;
            r2_mb  <= r1_mb;
            r2_bb  <= r1_mb * r1_mb;
            r2_ac  <= r1_ma * r1_mc;
        end
    end

    // stage 3: discriminant and classification
    logic [PW-1:0] fac, dsum, ddif;
    assign fac  = {r2_ac, 2'b00};
    assign dsum = PW'(r2_bb) + fac;
    assign ddif = PW'(r2_bb) - fac;

    logic              r3_v, r3_sa, r3_nb;
    logic [1:0]        r3_cnt;
    logic [W-1:0]      r3_ma, r3_mb;
    logic [PW-1:0]     r3_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (adv) begin
            r3_v <= r2_v;
        end
        if (adv) begin
            r3_sa <= r2_sa;
            r3_nb <= (r2_mb != '0) && !r2_sb;
            r3_ma <= r2_ma;
            r3_mb <= r2_mb;
            if (r2_az) begin
                r3_cnt <= qrs_pkg::CNT_NONE;
                r3_d   <= '0;
            end else if (r2_add) begin
                r3_cnt <= qrs_pkg::CNT_TWO;
                r3_d   <= dsum;
            end else if (fac > PW'(r2_bb)) begin
                r3_cnt <= qrs_pkg::CNT_NONE;
                r3_d   <= '0;
            end else if (ddif == '0) begin
                r3_cnt <= qrs_pkg::CNT_ONE;
                r3_d   <= '0;
            end else begin
                r3_cnt <= qrs_pkg::CNT_TWO;
                r3_d   <= ddif;
            end
        end
    end

    // square root, restoring, one bit per stage
    logic [NS:0]          s_v;
    logic [NS:0]          s_sa, s_nb;
    logic [1:0]           s_cnt [NS+1];
    logic [W-1:0]         s_ma  [NS+1];
    logic [W-1:0]         s_mb  [NS+1];
    logic [PW-1:0]        s_rem [NS+1];
    logic [PW-1:0]        s_d   [NS+1];
    logic [SW-1:0]        s_q   [NS+1];

    assign s_v[0]   = r3_v;
    assign s_sa[0]  = r3_sa;
    assign s_nb[0]  = r3_nb;
    assign s_cnt[0] = r3_cnt;
    assign s_ma[0]  = r3_ma;
    assign s_mb[0]  = r3_mb;
    assign s_rem[0] = '0;
    assign s_d[0]   = r3_d;
    assign s_q[0]   = '0;

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        logic [PW+1:0] rem2, trial;
        assign rem2  = {s_rem[k], s_d[k][PW-1:PW-2]};
        assign trial = rem2 - {PW'(s_q[k]), 2'b01};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_v[k+1] <= 1'b0;
            end else if (adv) begin
                s_v[k+1] <= s_v[k];
            end
            if (adv) begin
                s_sa[k+1]  <= s_sa[k];
                s_nb[k+1]  <= s_nb[k];
                s_cnt[k+1] <= s_cnt[k];
                s_ma[k+1]  <= s_ma[k];
                s_mb[k+1]  <= s_mb[k];
                s_d[k+1]   <= {s_d[k][PW-3:0], 2'b00};
                if (!trial[PW+1]) begin
                    s_rem[k+1] <= trial[PW-1:0];
                    s_q[k+1]   <= {s_q[k][SW-2:0], 1'b1};
                end else begin
                    s_rem[k+1] <= rem2[PW-1:0];
                    s_q[k+1]   <= {s_q[k][SW-2:0], 1'b0};
                end
            end
        end
    end

    // numerators in sign and magnitude
    logic [SW:0] sx, mbx, n1m, n2m;
    logic        n1s, n2s;
    assign sx  = {1'b0, s_q[NS]};
    assign mbx = (SW+1)'(s_mb[NS]);

    always_comb begin
        if (!s_nb[NS]) begin
            n1s = 1'b0;
            n1m = mbx + sx;
        end else if (mbx >= sx) begin
            n1s = 1'b1;
            n1m = mbx - sx;
        end else begin
            n1s = 1'b0;
            n1m = sx - mbx;
        end
        if (s_nb[NS] == (sx != '0)) begin
            n2s = s_nb[NS];
            n2m = mbx + sx;
        end else if (s_nb[NS]) begin
            n2s = 1'b1;
            n2m = mbx - sx;
        end else if (mbx >= sx) begin
            n2s = 1'b0;
            n2m = mbx - sx;
        end else begin
            n2s = 1'b1;
            n2m = sx - mbx;
        end
        if (s_cnt[NS] == qrs_pkg::CNT_ONE) begin
            n1s = s_nb[NS];
            n1m = mbx;
        end
        if (n1m == '0) n1s = 1'b0;
        if (n2m == '0) n2s = 1'b0;
    end

    logic           r4_v, r4_n1, r4_n2;
    logic [1:0]     r4_cnt;
    logic [NW-1:0]  r4_m1, r4_m2;
    logic [DW-1:0]  r4_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (adv) begin
            r4_v <= s_v[NS];
        end
        if (adv) begin
            r4_cnt <= s_cnt[NS];
            r4_n1  <= n1s ^ s_sa[NS];
            r4_n2  <= n2s ^ s_sa[NS];
            r4_m1  <= NW'(n1m);
            r4_m2  <= NW'(n2m);
            r4_den <= {s_ma[NS], 1'b0};
        end
    end

    // two restoring dividers, one quotient bit per stage
    logic [NQ:0]     q_v;
    logic [NQ:0]     q_n1, q_n2;
    logic [1:0]      q_cnt [NQ+1];
    logic [DW-1:0]   q_den [NQ+1];
    logic [XW-1:0]   q_x1  [NQ+1];
    logic [XW-1:0]   q_x2  [NQ+1];
    logic [DW-1:0]   q_r1  [NQ+1];
    logic [DW-1:0]   q_r2  [NQ+1];

    assign q_v[0]   = r4_v;
    assign q_n1[0]  = r4_n1;
    assign q_n2[0]  = r4_n2;
    assign q_cnt[0] = r4_cnt;
    assign q_den[0] = r4_den;
    assign q_x1[0]  = XW'(r4_m1) << FRAC_BITS;
    assign q_x2[0]  = XW'(r4_m2) << FRAC_BITS;
    assign q_r1[0]  = '0;
    assign q_r2[0]  = '0;

    for (genvar k = 0; k < NQ; k++) begin : g_div
        logic [DW:0] t1, t2, d1, d2;
        assign t1 = {q_r1[k], q_x1[k][XW-1]};
        assign t2 = {q_r2[k], q_x2[k][XW-1]};
        assign d1 = t1 - {1'b0, q_den[k]};
        assign d2 = t2 - {1'b0, q_den[k]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                q_v[k+1] <= 1'b0;
            end else if (adv) begin
                q_v[k+1] <= q_v[k];
            end
            if (adv) begin
                q_n1[k+1]  <= q_n1[k];
                q_n2[k+1]  <= q_n2[k];
                q_cnt[k+1] <= q_cnt[k];
                q_den[k+1] <= q_den[k];
                q_x1[k+1]  <= {q_x1[k][XW-2:0], ~d1[DW]};
                q_x2[k+1]  <= {q_x2[k][XW-2:0], ~d2[DW]};
                q_r1[k+1]  <= d1[DW] ? t1[DW-1:0] : d1[DW-1:0];
                q_r2[k+1]  <= d2[DW] ? t2[DW-1:0] : d2[DW-1:0];
            end
        end
    end

    // sign, saturation and output register
    function automatic logic [W:0] fix(input logic neg, input logic [XW-1:0] q);
        logic [XW:0]  lim;
        logic         ng;
        logic [W-1:0] mag;
        logic         sat;
        ng  = neg && (q != '0);
        lim = (XW+1)'({1'b1, (W-1)'(0)}) - (ng ? (XW+1)'(0) : (XW+1)'(1));
        sat = ((XW+1)'(q) > lim);
        mag = sat ? W'(lim) : W'(q);
        return {sat, ng ? W'(-mag) : mag};
    endfunction

    logic [W:0] f1, f2;
    assign f1 = fix(q_n1[NQ], q_x1[NQ]);
    assign f2 = fix(q_n2[NQ], q_x2[NQ]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (adv) begin
            o_valid <= q_v[NQ];
        end
        if (adv) begin
            o_root_count <= q_cnt[NQ];
            unique case (q_cnt[NQ])
                qrs_pkg::CNT_ONE: begin
                    o_root_first  <= f1[W-1:0];
                    o_root_second <= '0;
                    o_saturated   <= f1[W];
                end
                qrs_pkg::CNT_TWO: begin
                    o_root_first  <= f1[W-1:0];
                    o_root_second <= f2[W-1:0];
                    o_saturated   <= f1[W] | f2[W];
                end
                default: begin
                    o_root_first  <= '0;
                    o_root_second <= '0;
                    o_saturated   <= 1'b0;
                end
            endcase
        end
    end

    // checks
    a_zero_a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r1_v && r1_ma == '0) |=> (r2_az && r2_v))
        else $error("zero a not flagged");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_root_count != 2'd3))
        else $error("bad root count");
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_root_count == qrs_pkg::CNT_NONE) |->
        (o_root_first == '0 && o_root_second == '0 && !o_saturated))
        else $error("no-root word not cleared");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_root_first)))
        else $error("stalled word changed");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver testbench
// drives coefficient words through the solver pipeline and checks every
// result word against a local predictor of the fixed-point root arithmetic,
// under random sender gaps, receiver stalls and a long receiver hold-off
// ----------------------------------------------------------------------------
module testbench;

    localparam int W         = 32;
    localparam int FRAC      = 16;
    localparam int LATENCY   = 3 + (W + 1) + 1 + (W + 1 + FRAC) + 1;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        qrs_pkg::t_count count;
        logic [W-1:0]    first;
        logic [W-1:0]    second;
        logic            sat;
    } t_roots;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic signed [W-1:0] i_coef_a = '0;
    logic signed [W-1:0] i_coef_b = '0;
    logic signed [W-1:0] i_coef_c = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [1:0]          o_root_count;
    logic signed [W-1:0] o_root_first;
    logic signed [W-1:0] o_root_second;
    logic                o_saturated;

    t_roots pending_roots[$];
    int     error_count = 0;
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    bit     rx_hold = 1'b0;
    int     idle_cycles = 0;

    quadratic_root_solver u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_coef_a      (i_coef_a),
        .i_coef_b      (i_coef_b),
        .i_coef_c      (i_coef_c),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_root_count  (o_root_count),
        .o_root_first  (o_root_first),
        .o_root_second (o_root_second),
        .o_saturated   (o_saturated)
    );

    always #10 i_clk = ~i_clk;

    // quotient of a signed numerator by 2a, truncated and clipped
    function automatic logic [W-1:0] scaled_root(input bit num_neg, input logic [127:0] num_mag,
                                                 input bit a_neg, input logic [127:0] a_mag,
                                                 inout logic sat);
        logic [127:0] q;
        logic [127:0] lim;
        bit           neg;
        q   = (num_mag << FRAC) / (a_mag << 1);
        neg = (num_neg != a_neg) && (q != 0);
        lim = (128'd1 << (W-1)) - (neg ? 128'd0 : 128'd1);
        if (q > lim) begin
            q   = lim;
            sat = 1'b1;
        end
        return neg ? W'(-q) : W'(q);
    endfunction

    function automatic void signed_sum(input bit s1, input logic [127:0] m1, input bit s2,
                                       input logic [127:0] m2, output bit so,
                                       output logic [127:0] mo);
        if (s1 == s2) begin
            so = s1;
            mo = m1 + m2;
        end else if (m1 >= m2) begin
            so = s1;
            mo = m1 - m2;
        end else begin
            so = s2;
            mo = m2 - m1;
        end
        if (mo == 0) so = 1'b0;
    endfunction

    function automatic t_roots solve_quadratic(input logic [W-1:0] a, input logic [W-1:0] b,
                                               input logic [W-1:0] c);
        t_roots       r;
        bit           sa, sb, sc, ns, nb;
        logic [127:0] ma, mb, mc, bb, fac, d, s, cand, nm;
        r  = '{qrs_pkg::CNT_NONE, '0, '0, 1'b0};
        sa = a[W-1];
        sb = b[W-1];
        sc = c[W-1];
        ma = sa ? 128'(W'(-a)) : 128'(a);
        mb = sb ? 128'(W'(-b)) : 128'(b);
        mc = sc ? 128'(W'(-c)) : 128'(c);
        if (ma == 0) return r;
        bb = mb * mb;
        fac = (ma * mc) << 2;
        if (sa != sc && mc != 0) begin
            d = bb + fac;
        end else begin
            if (fac > bb) return r;
            d = bb - fac;
        end
        nb = (mb != 0) && !sb;
        if (d == 0) begin
            r.count = qrs_pkg::CNT_ONE;
            r.first = scaled_root(nb, mb, sa, ma, r.sat);
            return r;
        end
        s = 0;
        for (int i = 63; i >= 0; i--) begin
            cand = s | (128'd1 << i);
            if (cand * cand <= d) s = cand;
        end
        r.count = qrs_pkg::CNT_TWO;
        signed_sum(nb, mb, 1'b0, s, ns, nm);
        r.first = scaled_root(ns, nm, sa, ma, r.sat);
        signed_sum(nb, mb, s != 0, s, ns, nm);
        r.second = scaled_root(ns, nm, sa, ma, r.sat);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [W-1:0] got,
                                   input logic [W-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        i_ready <= rx_hold ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        t_roots want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_roots.size() == 0) begin
                report_mismatch("unexpected word", W'(o_root_count), '0);
            end else begin
                want = pending_roots.pop_front();
                if (o_root_count != want.count)
                    report_mismatch("root_count", W'(o_root_count), W'(want.count));
                if (o_root_first != want.first)
                    report_mismatch("root_first", o_root_first, want.first);
                if (o_root_second != want.second)
                    report_mismatch("root_second", o_root_second, want.second);
                if (o_saturated != want.sat)
                    report_mismatch("saturated", W'(o_saturated), W'(want.sat));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("** quadratic_root_solver: FAILED **");
            $finish;
        end
    end

    task automatic send_word(input logic [W-1:0] a, input logic [W-1:0] b,
                             input logic [W-1:0] c);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_coef_a <= a;
        i_coef_b <= b;
        i_coef_c <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_roots.push_back(solve_quadratic(a, b, c));
    endtask

    task automatic stop_sending();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // integer-root quadratic k*(x-r1)*(x-r2) in fixed point
    task automatic send_factored(input int k, input int r1, input int r2);
        send_word(W'(k) << FRAC, W'(-k * (r1 + r2)) << FRAC, W'(k * r1 * r2) << FRAC);
    endtask

    task automatic send_random_word();
        int pick;
        pick = $urandom_range(9);
        if (pick < 3)
            send_word($urandom, $urandom, $urandom);
        else if (pick < 6)
            send_factored($signed($urandom_range(0, 40)) - 20, $signed($urandom_range(0, 60)) - 30,
                          $signed($urandom_range(0, 60)) - 30);
        else if (pick < 8)
            send_word(W'($signed($urandom_range(0, 1 << 20)) - (1 << 19)),
                      W'($signed($urandom_range(0, 1 << 24)) - (1 << 23)),
                      W'($signed($urandom_range(0, 1 << 20)) - (1 << 19)));
        else
            send_word(W'($signed($urandom_range(0, 8)) - 4), $urandom, $urandom);
    endtask

    task automatic test_directed();
        send_word('0, 32'h0001_0000, 32'h0001_0000);
        send_word('0, '0, '0);
        send_word(32'h0001_0000, '0, 32'h0001_0000);
        send_factored(1, 1, 1);
        send_factored(-3, -2, -2);
        send_factored(1, 2, -3);
        send_factored(-2, 5, 7);
        send_word(32'h0001_0000, '0, '0);
        send_word(32'h0001_0000, '0, 32'hFFFF_0000);
        send_word(32'h0000_0001, 32'h7FFF_FFFF, '0);
        send_word(32'h0000_0001, 32'h8000_0000, '0);
        send_word(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(32'h7FFF_FFFF, '0, 32'h7FFF_FFFF);
        send_word(32'h0000_0001, 32'h0000_0002, 32'h0000_0001);
        send_word(32'h0000_0003, 32'h0000_0007, 32'h0000_0002);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'h0000_0001, 32'h0000_0003, 32'h0000_0001);
    endtask

    task automatic test_random(input int tx_pct, input int rx_pct, input int n);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (n) send_random_word();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fork
            begin
                rx_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            repeat (200) send_random_word();
        join
    endtask

    task automatic test_drain_pause();
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        repeat (20) send_random_word();
        stop_sending();
        while (pending_roots.size() != 0) @(posedge i_clk);
        repeat (20) send_random_word();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(9, 87, 120);
        test_random(87, 9, 120);
        test_random(0, 0, 160);
        test_backpressure();
        test_drain_pause();
        stop_sending();
        while (pending_roots.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** quadratic_root_solver: PASSED **");
        end else begin
            $display("** quadratic_root_solver: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/qrs_pkg.sv
rtl/core/quadratic_root_solver.sv
bench/testbench.sv
